### rtl/pwm_edge_interval_recorder_unit_macros.svh
// Assertion macros shared by the PWM edge interval recorder RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef PWM_EDGE_INTERVAL_RECORDER_UNIT_MACROS_SVH
`define PWM_EDGE_INTERVAL_RECORDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds whenever the antecedent holds.
`define PWMEIR_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed in %m");
// Check that a condition holds in the cycle after the antecedent.
`define PWMEIR_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed in %m");
`else
`define PWMEIR_ASSERT_NOW(lbl, ck, rstn, ante, cons)
`define PWMEIR_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

### rtl/pwmeir_pkg.sv
`timescale 1ns / 1ps
// Package for the PWM edge interval recorder: operation and result codes, result record type.
// No dependencies.
package pwmeir_pkg;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_RISE = 2'd0,
		OP_FALL = 2'd1,
		OP_END  = 2'd2
	} op_t;

	// Result kind codes.
	typedef enum logic [1:0] {
		KIND_TIME   = 2'd0,
		KIND_STOP   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	localparam int unsigned VAL_W = 32;
	localparam logic [VAL_W-1:0] VAL_ONE       = 32'h0000_0001;
	localparam logic [VAL_W-1:0] VAL_MINUS_ONE = 32'hFFFF_FFFF;

	// One input transaction's two results: a timestamp pair, or stop marker plus status.
	typedef struct packed {
		logic             is_end;
		logic [VAL_W-1:0] v0;
		logic [VAL_W-1:0] v1;
	} rec_t;

endpackage

### rtl/pwmeir_rec_queue.sv
`timescale 1ns / 1ps
// Two-entry result record queue that serializes each record into two output transactions.
// Depends on pwmeir_pkg and pwm_edge_interval_recorder_unit_macros.svh.
`include "pwm_edge_interval_recorder_unit_macros.svh"
module pwmeir_rec_queue import pwmeir_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  rec_t                    push_rec,
	output logic                    full,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              kind,
	output logic signed [VAL_W-1:0] value,
	output logic                    last
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rec_t             rec_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             phase_q;
	logic             out_fire;
	logic             pop;
	rec_t             head;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_fire  = out_valid && out_ready;
	assign pop       = out_fire && phase_q;
	assign head      = rec_q[rd_q];

	// Output fields: first half is the held edge or stop marker, second half ends the record.
	always_comb begin
		if (head.is_end) begin
			kind = phase_q ? KIND_STATUS : KIND_STOP;
		end else begin
			kind = KIND_TIME;
		end
		value = phase_q ? head.v1 : head.v0;
		last  = phase_q;
	end

	// Record storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			rec_q[wr_q] <= push_rec;
		end
	end

	// Pointers, occupancy and the half select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (out_fire) begin
				phase_q <= !phase_q;
			end
		end
	end

	`PWMEIR_ASSERT_NOW(a_no_push_when_full, clk, arst_n, full, !push)
	`PWMEIR_ASSERT_NOW(a_cnt_in_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`PWMEIR_ASSERT_NOW(a_phase_needs_entry, clk, arst_n, phase_q, out_valid)
	`PWMEIR_ASSERT_NEXT(a_first_half_follows, clk, arst_n, out_fire && !phase_q, out_valid && phase_q)

endmodule

### rtl/pwm_edge_interval_recorder_unit.sv
`timescale 1ns / 1ps
// PWM edge interval recorder: top level with input register, edge bookkeeping and result queue.
// Depends on pwmeir_pkg, pwmeir_rec_queue and pwm_edge_interval_recorder_unit_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, op, time_us) carries rising edges, falling edges and
//   end-of-recording transactions. The first SKIP_EDGES transitions set the reference time, and
//   falling edges after them move it until a rising edge comes; later edges are paired,
//   and each completed pair leaves as two timestamp results relative to the reference.
//   An end transaction gives a stop marker and a status word. Output channel (out_valid/
//   out_ready, kind, value, last) carries one result per transaction; last marks the
//   second result of a pair or the status word. An accepted input passes from the input
//   register to the result queue before its results are offered. Throughput: an input is
//   taken every cycle while the two-record result queue has room. Inputs that give results
//   leave as two transactions each on the single output port, which bounds their rate.
//   Reset (arst_n low) clears the edge count, held edge and queue at once.
//   When the receiver stalls, results wait in the queue; once it holds two records the
//   input register stops draining and in_ready falls until results are taken.
`include "pwm_edge_interval_recorder_unit_macros.svh"
module pwm_edge_interval_recorder_unit import pwmeir_pkg::*; #(
	parameter int unsigned SKIP_EDGES = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic [31:0]             time_us,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              kind,
	output logic signed [VAL_W-1:0] value,
	output logic                    last
);

	localparam int unsigned CNT_W = $clog2(SKIP_EDGES + 2);
	localparam logic [CNT_W-1:0] SKIP_C = CNT_W'(SKIP_EDGES);
	localparam logic [CNT_W-1:0] SAT_C  = CNT_W'(SKIP_EDGES + 1);

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [31:0]      time_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      ref_q;
	logic [31:0]      held_q;
	logic             held_v_q;
	logic             q_full;
	logic             fire;
	logic             push;
	rec_t             push_rec;

	assign fire     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			time_s1 <= time_us;
		end
	end

	// Result record for the transaction in the input register.
	always_comb begin
		push            = 1'b0;
		push_rec.is_end = 1'b0;
		push_rec.v0     = held_q - ref_q;
		push_rec.v1     = time_s1 - ref_q;
		case (op_s1)
			OP_END: begin
				push            = fire;
				push_rec.is_end = 1'b1;
				push_rec.v0     = VAL_MINUS_ONE;
				push_rec.v1     = (cnt_q == SAT_C) ? VAL_ONE : VAL_MINUS_ONE;
			end
			OP_RISE, OP_FALL: begin
				push = fire && held_v_q && (cnt_q > SKIP_C ||
					(cnt_q == SKIP_C && op_s1 == OP_RISE));
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Edge count, reference time and held edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ref_q    <= '0;
			held_q   <= '0;
			held_v_q <= 1'b0;
		end else if (fire) begin
			case (op_s1)
				OP_END: begin
					cnt_q    <= '0;
					ref_q    <= '0;
					held_q   <= '0;
					held_v_q <= 1'b0;
				end
				OP_RISE, OP_FALL: begin
					if (cnt_q < SKIP_C) begin
						ref_q <= time_s1;
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (cnt_q == SKIP_C && op_s1 == OP_FALL) begin
						ref_q <= time_s1;
					end else begin
						cnt_q <= SAT_C;
						if (!held_v_q) begin
							held_q   <= time_s1;
							held_v_q <= 1'b1;
						end else begin
							held_q   <= '0;
							held_v_q <= 1'b0;
						end
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	pwmeir_rec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	`PWMEIR_ASSERT_NOW(a_cnt_saturates, clk, arst_n, 1'b1, cnt_q <= SAT_C)
	`PWMEIR_ASSERT_NOW(a_held_after_skip, clk, arst_n, held_v_q, cnt_q == SAT_C)
	`PWMEIR_ASSERT_NEXT(a_end_clears, clk, arst_n, fire && op_s1 == OP_END, !held_v_q)
	`PWMEIR_ASSERT_NEXT(a_pair_releases_held, clk, arst_n, push && !push_rec.is_end, !held_v_q)

endmodule

### tb/tb_pwm_edge_interval_recorder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PWM edge interval recorder: directed and random edge streams.
// Depends on pwmeir_pkg and pwm_edge_interval_recorder_unit.
module tb_pwm_edge_interval_recorder_unit import pwmeir_pkg::*; ();

	localparam int unsigned SKIP_EDGES = 6;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CLK_HALF_NS = 6;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 16;
	localparam longint LIMIT_NS = 64'd8_000_000;
	localparam int ITEMS_PER_PHASE = 650;

	// One result as it should leave the block.
	typedef struct {
		kind_t       kind;
		logic [31:0] value;
		logic        last;
	} recorder_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_RISE;
	logic [31:0] time_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic signed [31:0] value;
	logic last;

	// Recorder state as the block should hold it.
	logic [3:0] edges_seen;
	logic [31:0] ref_us;
	logic [31:0] pair_first_us;
	logic pair_open;

	recorder_result_t recorder_results[$];
	int mismatches = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_request = 0;
	int stall_left = 0;

	pwm_edge_interval_recorder_unit #(
		.SKIP_EDGES(SKIP_EDGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.time_us  (time_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.value    (value),
		.last     (last)
	);

	always #CLK_HALF_NS clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#(LIMIT_NS);
		$display("tb_pwm_edge_interval_recorder_unit failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic clear_recording();
		edges_seen = '0;
		ref_us = '0;
		pair_first_us = '0;
		pair_open = 1'b0;
	endtask

	task automatic push_result(input kind_t k, input logic [31:0] v, input logic l);
		recorder_result_t r;
		r.kind = k;
		r.value = v;
		r.last = l;
		recorder_results.push_back(r);
	endtask

	// Update the recording with one accepted transaction and queue the results it causes.
	task automatic track_edge(input logic [1:0] code, input logic [31:0] t_us);
		case (code)
			OP_END: begin
				push_result(KIND_STOP, VAL_MINUS_ONE, 1'b0);
				push_result(KIND_STATUS,
					(edges_seen > SKIP_EDGES) ? VAL_ONE : VAL_MINUS_ONE, 1'b1);
				clear_recording();
			end
			OP_RISE, OP_FALL: begin
				if (edges_seen < SKIP_EDGES) begin
					ref_us = t_us;
					edges_seen = edges_seen + 4'd1;
				end else if (edges_seen == SKIP_EDGES && code == OP_FALL) begin
					// A falling edge at the boundary only moves the reference.
					ref_us = t_us;
				end else begin
					edges_seen = 4'(SKIP_EDGES + 1);
					if (!pair_open) begin
						pair_first_us = t_us;
						pair_open = 1'b1;
					end else begin
						push_result(KIND_TIME, pair_first_us - ref_us, 1'b0);
						push_result(KIND_TIME, t_us - ref_us, 1'b1);
						pair_open = 1'b0;
						pair_first_us = '0;
					end
				end
			end
			default: begin
				// The unused code leaves the recording untouched.
			end
		endcase
	endtask

	// Offer one transaction, with random idle cycles ahead of it, and wait for acceptance.
	task automatic send_item(input logic [1:0] code, input logic [31:0] t_us);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		time_us <= t_us;
		do @(posedge clk); while (!in_ready);
		track_edge(code, t_us);
	endtask

	// Stop offering and wait until every queued result has left the block.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (recorder_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, plus long hold-offs on request.
	always @(posedge clk) begin
		if (stall_request != 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each result transaction with the oldest pending one.
	always @(posedge clk) begin
		recorder_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (recorder_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d value %0d",
					kind, value));
			end else begin
				want = recorder_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (value !== want.value)
					report_mismatch($sformatf("value %0d, want %0d", value,
						$signed(want.value)));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	// Discarded edges with extreme times, two boundary falls, an unused code, a wrapped pair and the end.
	task automatic test_skip_and_first_pair();
		send_item(OP_RISE, 32'h0000_0000);
		send_item(OP_FALL, 32'hFFFF_FFFF);
		send_item(OP_RISE, 32'h8000_0000);
		send_item(OP_FALL, 32'h7FFF_FFFF);
		send_item(OP_RISE, 32'h5555_5555);
		send_item(OP_FALL, 32'hAAAA_AAAA);
		send_item(OP_FALL, 32'd450);
		send_item(OP_FALL, 32'd500);
		send_item(OP_UNUSED, 32'hFFFF_FFFF);
		send_item(OP_RISE, 32'd16);
		send_item(OP_FALL, 32'd4);
		send_item(OP_END, 32'h0000_0000);
	endtask

	// End with no edges at all, and end before the skipped edges are complete.
	task automatic test_short_recordings();
		send_item(OP_END, 32'hFFFF_FFFF);
		send_item(OP_RISE, 32'd10);
		send_item(OP_FALL, 32'd20);
		send_item(OP_RISE, 32'd30);
		send_item(OP_END, 32'd40);
	endtask

	// A kept edge with no partner is dropped by the end transaction.
	task automatic test_unpaired_edge_dropped();
		for (int i = 0; i < SKIP_EDGES; i++)
			send_item((i % 2) ? OP_FALL : OP_RISE, 32'd1000 + 32'(i));
		send_item(OP_RISE, 32'd2000);
		send_item(OP_END, 32'd3000);
	endtask

	// Random recordings: mostly well formed, some too short, some unterminated, some noise.
	task automatic test_random_recordings(input int n_items, input int tx_pct, input int rx_pct);
		int sent;
		int n_edges;
		logic [31:0] t_us;
		logic [1:0] code;
		logic level;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					code = 2'($urandom_range(3));
					send_item(code, $urandom);
					if (code != OP_UNUSED)
						sent++;
				end
			end else begin
				if ($urandom_range(7) == 0)
					n_edges = $urandom_range(0, SKIP_EDGES + 1);
				else
					n_edges = $urandom_range(SKIP_EDGES + 1, SKIP_EDGES + 24);
				t_us = $urandom;
				level = 1'($urandom_range(1));
				for (int i = 0; i < n_edges; i++) begin
					// Mostly short steps; now and then a huge one that wraps the timer.
					if ($urandom_range(15) == 0)
						t_us = t_us + $urandom;
					else
						t_us = t_us + $urandom_range(1, 5000);
					send_item(level ? OP_FALL : OP_RISE, t_us);
					level = ~level;
					sent++;
				end
				if ($urandom_range(15) != 0) begin
					send_item(OP_END, $urandom);
					sent++;
				end
			end
		end
	endtask

	// Hold the receiver off for a long stretch while edge pairs keep coming in.
	task automatic test_backpressure();
		logic [31:0] t_us;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_request = 300;
		t_us = 32'd100;
		for (int i = 0; i < 40; i++) begin
			t_us = t_us + $urandom_range(1, 300);
			send_item((i % 2) ? OP_FALL : OP_RISE, t_us);
		end
		send_item(OP_END, $urandom);
	endtask

	// Test sequence.
	initial begin
		clear_recording();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		tx_idle_pct = 25;
		rx_idle_pct = 67;
		test_skip_and_first_pair();
		test_short_recordings();
		test_unpaired_edge_dropped();
		test_backpressure();
		test_random_recordings(ITEMS_PER_PHASE, 25, 67);
		test_random_recordings(ITEMS_PER_PHASE, 67, 25);
		test_random_recordings(ITEMS_PER_PHASE, 0, 0);
		wait_drained();

		if (mismatches == 0)
			$display("tb_pwm_edge_interval_recorder_unit passed");
		else
			$display("tb_pwm_edge_interval_recorder_unit failed");
		$finish;
	end

endmodule
